[hdl/hnt_pkg.sv]
// ----------------------------------------------------------------------------
// hnt_pkg
// Shared constants, codes and types of the hello neighbor table.
// ----------------------------------------------------------------------------
package hnt_pkg;

	localparam int NUM_PORTS        = 4;
	localparam int MAX_NEIGHBORS    = 8;
	localparam int NEIGHBOR_TIMEOUT = 30;
	localparam int MIN_BODY_LENGTH  = 32;

	localparam int SLOTS  = NUM_PORTS * MAX_NEIGHBORS;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NB_W   = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);

	localparam int CFG_PORTS = 4;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_MASK_BASE     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_BASE = 8'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_END           = 8'd8;

	localparam logic [15:0] INTERVAL_RESET = 16'd10;

	localparam int S_TDATA_W = 168;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = 3;
	localparam int COUNT_W   = 4;

	typedef enum logic [2:0] {
		ST_REFRESHED = 3'd0,
		ST_ADDED     = 3'd1,
		ST_TOO_SHORT = 3'd2,
		ST_MISMATCH  = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SWEEP,
		FSM_DECIDE,
		FSM_REPORT
	} fsm_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] router;
	} ident_t;

endpackage

[hdl/hello_neighbor_table_top.sv]
// ----------------------------------------------------------------------------
// hello_neighbor_table_top
// Neighbor table for received link-state hellos: ages all entries, checks
// mask and interval, refreshes or adds the sender, reports one status beat.
// ----------------------------------------------------------------------------
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: hello fields
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: count, tuser: status
// cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// For a hello of full length the aging sweep reads the expiry memory once
// per slot, one slot a cycle; a short hello skips the sweep.
// Reset clears valid bits and control at once; memories are not cleared.
// The result register frees the input: a new hello is taken while a
// result waits, and only the report step waits on m_axis_tready.
// ----------------------------------------------------------------------------
module hello_neighbor_table_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// body_length[15:0], port_index[17:16], hello_mask[49:18],
	// hello_interval[65:50], source_addr[97:66], router_ident[129:98],
	// now_seconds[161:130], zero fill
	input  logic [hnt_pkg::S_TDATA_W-1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// port_neighbors[3:0], zero fill
	output logic [hnt_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// status[2:0]
	output logic [hnt_pkg::M_TUSER_W-1:0] m_axis_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hnt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	localparam int SLOT_W = hnt_pkg::SLOT_W;
	localparam int NB_W   = hnt_pkg::NB_W;
	localparam int CNT_W  = hnt_pkg::CNT_W;
	localparam int MAXN   = hnt_pkg::MAX_NEIGHBORS;

	hnt_pkg::fsm_t    state_q, next_state;
	hnt_pkg::status_t status_q;

	logic [31:0] mask_q     [hnt_pkg::CFG_PORTS];
	logic [15:0] interval_q [hnt_pkg::CFG_PORTS];

	logic [1:0]  port_q;
	logic [31:0] hmask_q, src_q, rid_q, now_q;
	logic [15:0] hint_q;

	logic [CNT_W-1:0]         cnt_q;
	logic                     rd_s1, id_s1;
	logic [SLOT_W-1:0]        idx_s1;
	logic [NB_W-1:0]          nb_s1;
	logic [MAXN-1:0]          match_q;
	logic [hnt_pkg::SLOTS-1:0] valid_q;

	logic [31:0]     exp_mem [hnt_pkg::SLOTS];
	hnt_pkg::ident_t id_mem  [hnt_pkg::SLOTS];
	logic [31:0]     exp_rdata_s1;
	hnt_pkg::ident_t id_rdata_s1;

	logic                         out_valid_q;
	logic [hnt_pkg::COUNT_W-1:0]  out_count_q;
	hnt_pkg::status_t             out_status_q;

	logic              accept, short_hello, port_ok, rd_en, id_rd_en, decide, out_load;
	logic [SLOT_W-1:0] base, rd_addr, id_rd_addr;
	logic [MAXN-1:0]   grp;
	logic              mismatch, found, free_any;
	logic [NB_W-1:0]   match_idx, free_idx;
	logic              exp_we, id_we;
	logic [SLOT_W-1:0] exp_wa, id_wa;
	logic [31:0]       expiry;
	hnt_pkg::status_t  status_d;
	logic [hnt_pkg::COUNT_W-1:0] count;

	assign s_axis_tready = (state_q == hnt_pkg::FSM_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign short_hello   = s_axis_tdata[15:0] < 16'(hnt_pkg::MIN_BODY_LENGTH);
	assign cfg_ready     = 1'b1;

	assign port_ok = int'(port_q) < hnt_pkg::NUM_PORTS;
	assign base    = SLOT_W'(int'(port_q) * MAXN);
	assign expiry  = now_q + 32'(hnt_pkg::NEIGHBOR_TIMEOUT);

	always_comb begin
		for (int k = 0; k < MAXN; k++) begin
			grp[k] = port_ok && valid_q[base + SLOT_W'(k)];
		end
	end

	always_comb begin
		count = '0;
		for (int k = 0; k < MAXN; k++) begin
			count = count + hnt_pkg::COUNT_W'(grp[k]);
		end
	end

	always_comb begin
		found     = |(match_q & grp);
		free_any  = ~&grp;
		match_idx = '0;
		free_idx  = '0;
		for (int k = MAXN - 1; k >= 0; k--) begin
			if (match_q[k] && grp[k]) begin
				match_idx = NB_W'(k);
			end
			if (!grp[k]) begin
				free_idx = NB_W'(k);
			end
		end
		mismatch = !port_ok || (mask_q[port_q] != hmask_q) || (interval_q[port_q] != hint_q);
	end

	always_comb begin
		next_state = state_q;
		case (state_q)
			hnt_pkg::FSM_IDLE: begin
				if (accept) begin
					next_state = short_hello ? hnt_pkg::FSM_REPORT : hnt_pkg::FSM_SWEEP;
				end
			end
			hnt_pkg::FSM_SWEEP: begin
				if (cnt_q == CNT_W'(hnt_pkg::SLOTS)) begin
					next_state = hnt_pkg::FSM_DECIDE;
				end
			end
			hnt_pkg::FSM_DECIDE: next_state = hnt_pkg::FSM_REPORT;
			hnt_pkg::FSM_REPORT: begin
				if (!out_valid_q || m_axis_tready) begin
					next_state = hnt_pkg::FSM_IDLE;
				end
			end
			default: next_state = hnt_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		rd_en      = 1'b0;
		id_rd_en   = 1'b0;
		decide     = 1'b0;
		out_load   = 1'b0;
		rd_addr    = cnt_q[SLOT_W-1:0];
		id_rd_addr = base + SLOT_W'(cnt_q);
		case (state_q)
			hnt_pkg::FSM_SWEEP: begin
				rd_en    = cnt_q < CNT_W'(hnt_pkg::SLOTS);
				id_rd_en = port_ok && (cnt_q < CNT_W'(MAXN));
			end
			hnt_pkg::FSM_DECIDE: decide = 1'b1;
			hnt_pkg::FSM_REPORT: out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	always_comb begin
		exp_we   = decide && !mismatch && (found || free_any);
		id_we    = decide && !mismatch && !found && free_any;
		exp_wa   = base + SLOT_W'(found ? match_idx : free_idx);
		id_wa    = base + SLOT_W'(free_idx);
		status_d = hnt_pkg::ST_FULL;
		if (mismatch) begin
			status_d = hnt_pkg::ST_MISMATCH;
		end else if (found) begin
			status_d = hnt_pkg::ST_REFRESHED;
		end else if (free_any) begin
			status_d = hnt_pkg::ST_ADDED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hnt_pkg::FSM_IDLE;
			rd_s1   <= 1'b0;
			id_s1   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= next_state;
			rd_s1   <= rd_en;
			id_s1   <= id_rd_en;
			if (accept) begin
				cnt_q <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		nb_s1  <= NB_W'(cnt_q);
		if (accept) begin
			port_q  <= s_axis_tdata[17:16];
			hmask_q <= s_axis_tdata[49:18];
			hint_q  <= s_axis_tdata[65:50];
			src_q   <= s_axis_tdata[97:66];
			rid_q   <= s_axis_tdata[129:98];
			now_q   <= s_axis_tdata[161:130];
			match_q <= '0;
			if (short_hello) begin
				status_q <= hnt_pkg::ST_TOO_SHORT;
			end
		end else if (id_s1) begin
			match_q[nb_s1] <= (id_rdata_s1.addr == src_q);
		end
		if (decide) begin
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rd_s1 && valid_q[idx_s1] && (exp_rdata_s1 < now_q)) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (id_we) begin
				valid_q[id_wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exp_we) begin
			exp_mem[exp_wa] <= expiry;
		end
		if (rd_en) begin
			exp_rdata_s1 <= exp_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (id_we) begin
			id_mem[id_wa] <= '{addr: src_q, router: rid_q};
		end
		if (id_rd_en) begin
			id_rdata_s1 <= id_mem[id_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < hnt_pkg::CFG_PORTS; k++) begin
				mask_q[k]     <= '0;
				interval_q[k] <= hnt_pkg::INTERVAL_RESET;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index < hnt_pkg::CFG_INTERVAL_BASE) begin
				mask_q[cfg_index[1:0]] <= cfg_data;
			end else if (cfg_index < hnt_pkg::CFG_END) begin
				interval_q[cfg_index[1:0]] <= cfg_data[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_count_q  <= count;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {{(hnt_pkg::M_TDATA_W - hnt_pkg::COUNT_W){1'b0}}, out_count_q};

	a_valid_set: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q & ~$past(valid_q)) != '0 |->
			$past(state_q) == hnt_pkg::FSM_DECIDE && $countones(valid_q & ~$past(valid_q)) == 1)
		else $error("neighbor added outside the decide step");

	a_valid_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(~valid_q & $past(valid_q)) != '0 |-> $past(state_q) == hnt_pkg::FSM_SWEEP)
		else $error("neighbor removed outside the aging sweep");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == hnt_pkg::FSM_REPORT)
		else $error("result beat raised outside the report step");

endmodule

[dv/hello_neighbor_table_top_test.sv]
// ----------------------------------------------------------------------------
// hello_neighbor_table_top_test
// Drives link-state hellos and register writes into the neighbor table. A
// tracker class keeps its own copy of the registers and slots, works out the
// status and neighbor count of every accepted hello, and checks each result
// beat in order. Both sides idle at random; the receiver holds off once for
// a long stretch so that the table backs up and stalls its input.
// ----------------------------------------------------------------------------
module hello_neighbor_table_top_test;

	localparam int POOL  = 12;
	localparam int LIMIT = 500000;
	localparam int HOLD  = 400;

	typedef struct packed {
		logic [31:0] now_seconds;
		logic [31:0] router_ident;
		logic [31:0] source_addr;
		logic [15:0] hello_interval;
		logic [31:0] hello_mask;
		logic [1:0]  port_index;
		logic [15:0] body_length;
	} hello_t;

	typedef struct {
		hnt_pkg::status_t status;
		logic [3:0]       count;
	} report_t;

	class neighbor_tracker_t;
		logic [31:0] mask_reg [hnt_pkg::NUM_PORTS];
		logic [15:0] interval_reg [hnt_pkg::NUM_PORTS];
		bit          slot_live [hnt_pkg::SLOTS];
		logic [31:0] slot_addr [hnt_pkg::SLOTS];
		logic [31:0] slot_router [hnt_pkg::SLOTS];
		logic [31:0] slot_expiry [hnt_pkg::SLOTS];
		report_t     due_reports [$];
		int          errors;

		function new();
			for (int p = 0; p < hnt_pkg::NUM_PORTS; p++) begin
				mask_reg[p] = '0;
				interval_reg[p] = hnt_pkg::INTERVAL_RESET;
			end
			for (int k = 0; k < hnt_pkg::SLOTS; k++)
				slot_live[k] = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [hnt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
			if (idx < hnt_pkg::CFG_INTERVAL_BASE)
				mask_reg[idx[1:0]] = data;
			else if (idx < hnt_pkg::CFG_END)
				interval_reg[idx[1:0]] = data[15:0];
		endfunction

		function void take_hello(hello_t h);
			report_t     rep;
			logic [31:0] expiry;
			int          base;
			int          cnt;
			bit          found;
			expiry = h.now_seconds + hnt_pkg::NEIGHBOR_TIMEOUT;
			base = h.port_index * hnt_pkg::MAX_NEIGHBORS;
			if (h.body_length < hnt_pkg::MIN_BODY_LENGTH) begin
				rep.status = hnt_pkg::ST_TOO_SHORT;
			end else begin
				for (int k = 0; k < hnt_pkg::SLOTS; k++)
					if (slot_live[k] && slot_expiry[k] < h.now_seconds)
						slot_live[k] = 0;
				if (h.port_index >= hnt_pkg::NUM_PORTS ||
						mask_reg[h.port_index] != h.hello_mask ||
						interval_reg[h.port_index] != h.hello_interval) begin
					rep.status = hnt_pkg::ST_MISMATCH;
				end else begin
					found = 0;
					for (int k = 0; k < hnt_pkg::MAX_NEIGHBORS; k++) begin
						if (slot_live[base + k] && slot_addr[base + k] == h.source_addr) begin
							slot_expiry[base + k] = expiry;
							found = 1;
						end
					end
					if (found) begin
						rep.status = hnt_pkg::ST_REFRESHED;
					end else begin
						rep.status = hnt_pkg::ST_FULL;
						for (int k = 0; k < hnt_pkg::MAX_NEIGHBORS; k++) begin
							if (rep.status == hnt_pkg::ST_FULL && !slot_live[base + k]) begin
								slot_live[base + k] = 1;
								slot_addr[base + k] = h.source_addr;
								slot_router[base + k] = h.router_ident;
								slot_expiry[base + k] = expiry;
								rep.status = hnt_pkg::ST_ADDED;
							end
						end
					end
				end
			end
			cnt = 0;
			if (h.port_index < hnt_pkg::NUM_PORTS)
				for (int k = 0; k < hnt_pkg::MAX_NEIGHBORS; k++)
					cnt += slot_live[base + k];
			rep.count = 4'(cnt);
			due_reports.push_back(rep);
		endfunction

		function void check_report(logic [hnt_pkg::M_TUSER_W-1:0] status_bits,
				logic [hnt_pkg::M_TDATA_W-1:0] data);
			report_t rep;
			if (due_reports.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: status %0d tdata 0x%02h", status_bits, data);
				return;
			end
			rep = due_reports.pop_front();
			if (status_bits !== rep.status || data !== hnt_pkg::M_TDATA_W'(rep.count)) begin
				errors++;
				if (errors <= 10)
					$display({"beat mismatch: status exp %0d got %0d, ",
						"count exp %0d got tdata 0x%02h"},
						rep.status, status_bits, rep.count, data);
			end
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                s_axis_tvalid;
	logic                                s_axis_tready;
	logic [hnt_pkg::S_TDATA_W-1:0]       s_axis_tdata;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready;
	logic [hnt_pkg::M_TDATA_W-1:0]       m_axis_tdata;
	logic [hnt_pkg::M_TUSER_W-1:0]       m_axis_tuser;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [hnt_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [31:0]                         cfg_data;

	neighbor_tracker_t tracker;
	bit                gaps_on = 1;
	bit                hold_req = 0;
	int                hold_left = 0;
	int unsigned       cycles = 0;

	hello_neighbor_table_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("hello_neighbor_table_top_test failed");
			$finish;
		end
	end

	initial begin
		m_axis_tready <= 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
				tracker.check_report(m_axis_tuser, m_axis_tdata);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 0;
			end else if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 18);
			end
		end
	end

	function automatic hello_t mk(logic [15:0] len, logic [1:0] port, logic [31:0] mask,
			logic [15:0] ival, logic [31:0] src, logic [31:0] rid, logic [31:0] now);
		hello_t h;
		h.body_length = len;
		h.port_index = port;
		h.hello_mask = mask;
		h.hello_interval = ival;
		h.source_addr = src;
		h.router_ident = rid;
		h.now_seconds = now;
		return h;
	endfunction

	task automatic offer_hello(hello_t h);
		while (gaps_on && $urandom_range(0, 99) < 18) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= hnt_pkg::S_TDATA_W'(h);
		@(posedge clk);
		while (s_axis_tready !== 1'b1)
			@(posedge clk);
		tracker.take_hello(h);
	endtask

	task automatic write_reg(logic [hnt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		tracker.write_reg(idx, data);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (tracker.due_reports.size() != 0)
			@(posedge clk);
		repeat (hnt_pkg::SLOTS + 8) @(posedge clk);
	endtask

	initial begin
		hello_t      h;
		int          r;
		int          roll;
		logic [31:0] clock_s;
		logic [31:0] val;
		logic [15:0] ival;
		logic [31:0] pool [hnt_pkg::NUM_PORTS * POOL];
		tracker = new();
		arst_n <= 0;
		s_axis_tvalid <= 0;
		s_axis_tdata <= '0;
		cfg_valid <= 0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset settings: mask zero, interval ten
		offer_hello(mk(16'd0, 2'd0, 32'd0, 16'd10, 32'h0A000001, 32'h01010101, 32'd5));
		offer_hello(mk(16'hFFFF, 2'd3, 32'd0, 16'd10, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd5));
		drain();

		write_reg(hnt_pkg::CFG_MASK_BASE + 8'd0, 32'hFFFFFF00);
		write_reg(hnt_pkg::CFG_MASK_BASE + 8'd1, 32'hFFFFFFFF);
		write_reg(hnt_pkg::CFG_MASK_BASE + 8'd2, 32'h00000000);
		write_reg(hnt_pkg::CFG_MASK_BASE + 8'd3, 32'hFFFF0000);
		write_reg(hnt_pkg::CFG_INTERVAL_BASE + 8'd0, 32'hFFFF000A);
		write_reg(hnt_pkg::CFG_INTERVAL_BASE + 8'd1, 32'h0000FFFF);
		write_reg(hnt_pkg::CFG_INTERVAL_BASE + 8'd2, 32'h00000000);
		write_reg(hnt_pkg::CFG_INTERVAL_BASE + 8'd3, 32'h0000001E);
		write_reg(hnt_pkg::CFG_END, $urandom());
		write_reg(8'hFF, 32'hFFFFFFFF);

		offer_hello(mk(16'd31, 2'd0, 32'hFFFFFF00, 16'd10, 32'h0A000001, 32'h1, 32'd100));
		offer_hello(mk(16'd32, 2'd0, 32'hFFFFFF00, 16'd10, 32'h0A000001, 32'h1, 32'd100));
		offer_hello(mk(16'd40, 2'd0, 32'hFFFFFF00, 16'd10, 32'h0A000001, 32'h2, 32'd110));
		offer_hello(mk(16'd40, 2'd0, 32'hFFFFFFFF, 16'd10, 32'h0A000002, 32'h3, 32'd110));
		offer_hello(mk(16'd40, 2'd0, 32'hFFFFFF00, 16'd11, 32'h0A000002, 32'h3, 32'd110));
		for (int k = 0; k < hnt_pkg::MAX_NEIGHBORS + 1; k++)
			offer_hello(mk(16'hFFFF, 2'd1, 32'hFFFFFFFF, 16'hFFFF, 32'hC0A80000 + k,
				32'h100 + k, 32'd120));
		offer_hello(mk(16'd64, 2'd1, 32'hFFFFFFFF, 16'hFFFF, 32'hC0A80003, 32'h0, 32'd121));
		offer_hello(mk(16'd20, 2'd1, 32'h0, 16'h0, 32'h0, 32'h0, 32'd300));
		offer_hello(mk(16'd32, 2'd2, 32'h0, 16'h0, 32'h0, 32'h0, 32'd200));
		offer_hello(mk(16'd0, 2'd1, 32'h0, 16'h0, 32'h0, 32'h0, 32'd200));
		// expiry equal to the time stays, one second later it goes
		offer_hello(mk(16'd32, 2'd2, 32'h0, 16'h0, 32'h1, 32'h0, 32'd230));
		offer_hello(mk(16'd32, 2'd2, 32'h0, 16'h0, 32'h2, 32'h0, 32'd231));
		// expiry wraps past zero
		offer_hello(mk(16'd32, 2'd3, 32'hFFFF0000, 16'd30, 32'h0B000001, 32'h5, 32'hFFFFFFF0));
		offer_hello(mk(16'd32, 2'd3, 32'hFFFF0000, 16'd30, 32'h0B000002, 32'h6, 32'hFFFFFFF5));
		offer_hello(mk(16'd32, 2'd3, 32'hFFFF0000, 16'd30, 32'h0B000002, 32'h7, 32'd0));

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			for (int p = 0; p < hnt_pkg::NUM_PORTS; p++) begin
				case ($urandom_range(0, 3))
					0: val = '0;
					1: val = '1;
					2: val = 32'hFFFFFFFF << $urandom_range(0, 31);
					default: val = $urandom();
				endcase
				write_reg(hnt_pkg::CFG_MASK_BASE + 8'(p), val);
				case ($urandom_range(0, 3))
					0: ival = '0;
					1: ival = '1;
					default: ival = 16'($urandom());
				endcase
				write_reg(hnt_pkg::CFG_INTERVAL_BASE + 8'(p), {16'($urandom()), ival});
			end
			for (int k = 0; k < hnt_pkg::NUM_PORTS * POOL; k++)
				pool[k] = $urandom();
			clock_s = $urandom();
			gaps_on = (ph != 1);
			if (ph == 2)
				hold_req = 1;
			for (int n = 0; n < 444; n++) begin
				roll = $urandom_range(0, 99);
				if (roll >= 97)
					clock_s = (roll == 99) ? $urandom() : clock_s + $urandom_range(31, 90);
				else if (roll >= 90)
					clock_s += $urandom_range(2, 5);
				else if (roll >= 60)
					clock_s += 1;
				h.port_index = $urandom_range(0, 3);
				h.body_length = $urandom_range(hnt_pkg::MIN_BODY_LENGTH, 16'hFFFF);
				h.hello_mask = tracker.mask_reg[h.port_index];
				h.hello_interval = tracker.interval_reg[h.port_index];
				h.source_addr = pool[h.port_index * POOL + $urandom_range(0, POOL - 1)];
				h.router_ident = $urandom();
				h.now_seconds = clock_s;
				r = $urandom_range(0, 99);
				if (r < 6) begin
					h.body_length = $urandom_range(0, hnt_pkg::MIN_BODY_LENGTH - 1);
				end else if (r < 10) begin
					h.hello_mask ^= 32'd1 << $urandom_range(0, 31);
				end else if (r < 13) begin
					h.hello_interval ^= 16'd1 << $urandom_range(0, 15);
				end else if (r < 15) begin
					h = mk(16'($urandom()), 2'($urandom()), $urandom(), 16'($urandom()),
						$urandom(), $urandom(), $urandom());
				end
				offer_hello(h);
			end
			gaps_on = 1;
		end

		drain();
		if (tracker.errors == 0 && tracker.due_reports.size() == 0)
			$display("hello_neighbor_table_top_test passed");
		else
			$display("hello_neighbor_table_top_test failed");
		$finish;
	end

endmodule
